### rtl/phws_pkg.sv
// Shared types, widths and constants of the heading PID waypoint stepper.
// Used by every module under rtl/; depends on nothing.
package phws_pkg;

  // Table depth default
  localparam int MAX_WAYPOINTS_DEF = 8;

  // Field and register widths
  localparam int HEAD_W  = 16;
  localparam int ELAP_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 15;
  localparam int CNT_W   = 4;
  localparam int SLOT_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // Datapath widths
  localparam int ERR_W   = 17;   // target - yaw
  localparam int DIFF_W  = 18;   // err - last_err
  localparam int SUM_W   = 48;   // integral accumulator
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = 40;
  localparam int DNUM_W  = 36;   // |diff| * gain_d * 4
  localparam int DDEN_W  = 16;
  localparam int DIV_STEPS = DNUM_W / 2;
  localparam int DCNT_W  = $clog2(DIV_STEPS + 1);
  localparam int ACC_W   = 64;
  localparam int P_SHIFT = 8;
  localparam int I_SHIFT = 18;
  localparam int P_W     = 26;
  localparam int I_W     = 47;
  localparam int D_W     = 37;
  localparam int TOT_W   = 49;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_P_RST   = 16'd307;
  localparam logic [GAIN_W-1:0] GAIN_I_RST   = 16'd26;
  localparam logic [GAIN_W-1:0] GAIN_D_RST   = 16'd77;
  localparam logic [LIM_W-1:0]  DRIVE_LIM_RST = 15'd4096;
  localparam logic [LIM_W-1:0]  ARRIVE_TOL_RST = 15'd41;
  localparam logic [CNT_W-1:0]  WP_COUNT_RST = 4'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_DRIVE_LIM  = 3'd3,
    REG_ARRIVE_TOL = 3'd4,
    REG_WP_COUNT   = 3'd5
  } cfg_reg_t;

  // Operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MUL_DIFF_GD = 3'd0,
    MUL_ERR_EL  = 3'd1,
    MUL_ERR_GP  = 3'd2,
    MUL_SUM_LO  = 3'd3,
    MUL_SUM_HI  = 3'd4
  } mul_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     table_write;
    logic     capture;
    logic     load_err;
    mul_sel_t mul_sel;
    logic     div_start;
    logic     load_sum;
    logic     load_p;
    logic     load_acc_lo;
    logic     load_acc_hi;
    logic     load_i;
    logic     load_total;
    logic     commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic finished;
    logic div_busy;
    logic out_busy;
  } sts_t;

endpackage

### rtl/phws_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies beyond phws_pkg for parameter defaults.
module phws_ram #(
  parameter int WIDTH = phws_pkg::HEAD_W,
  parameter int DEPTH = phws_pkg::MAX_WAYPOINTS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/phws_div.sv
// Restoring unsigned divider, two quotient bits per cycle.
// Divides the derivative numerator by elapsed time; uses phws_pkg widths.
module phws_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [phws_pkg::DNUM_W-1:0] num,
  input  logic [phws_pkg::DDEN_W-1:0] den,
  output logic                        busy,
  output logic [phws_pkg::DNUM_W-1:0] quo
);

  logic [phws_pkg::DDEN_W-1:0] rem;
  logic [phws_pkg::DCNT_W-1:0] cnt;
  logic [phws_pkg::DDEN_W:0]   r1, r2;
  logic [phws_pkg::DDEN_W-1:0] rem1, rem2;
  logic                        ge1, ge2;

  // Two dependent compare/subtract steps
  always_comb begin
    r1   = {rem, quo[phws_pkg::DNUM_W-1]};
    ge1  = r1 >= {1'b0, den};
    rem1 = ge1 ? phws_pkg::DDEN_W'(r1 - {1'b0, den}) : phws_pkg::DDEN_W'(r1);
    r2   = {rem1, quo[phws_pkg::DNUM_W-2]};
    ge2  = r2 >= {1'b0, den};
    rem2 = ge2 ? phws_pkg::DDEN_W'(r2 - {1'b0, den}) : phws_pkg::DDEN_W'(r2);
  end

  assign busy = (cnt != '0);

  // Shift register holds dividend, fills with quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= phws_pkg::DCNT_W'(phws_pkg::DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[phws_pkg::DNUM_W-3:0], ge1, ge2};
      rem <= rem2;
    end
  end

endmodule

### rtl/phws_dp.sv
// Datapath: config registers, target table, PID arithmetic, shared multiplier,
// divider and output register. Uses phws_pkg, phws_ram and phws_div.
module phws_dp #(
  parameter int MAX_WAYPOINTS = phws_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   cfg_we,
  input  logic [phws_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [phws_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  // input item fields
  input  logic [phws_pkg::SLOT_W-1:0]            in_slot,
  input  logic signed [phws_pkg::HEAD_W-1:0]     in_heading,
  input  logic [phws_pkg::ELAP_W-1:0]            in_elapsed,
  // control
  input  phws_pkg::cmd_t                         cmd,
  output phws_pkg::sts_t                         sts,
  // result
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [phws_pkg::HEAD_W-1:0]     out_drive,
  output logic                                   out_reached,
  output logic [phws_pkg::CNT_W-1:0]             out_wp,
  output logic                                   out_done
);

  localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam logic [phws_pkg::CNT_W-1:0] MAX_CNT = (MAX_WAYPOINTS > 15) ?
    {phws_pkg::CNT_W{1'b1}} : phws_pkg::CNT_W'(MAX_WAYPOINTS);

  // Configuration registers
  logic [phws_pkg::GAIN_W-1:0] gain_p, gain_i, gain_d;
  logic [phws_pkg::LIM_W-1:0]  drive_limit, arrive_tol;
  logic [phws_pkg::CNT_W-1:0]  wp_count, cnt_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p      <= phws_pkg::GAIN_P_RST;
      gain_i      <= phws_pkg::GAIN_I_RST;
      gain_d      <= phws_pkg::GAIN_D_RST;
      drive_limit <= phws_pkg::DRIVE_LIM_RST;
      arrive_tol  <= phws_pkg::ARRIVE_TOL_RST;
      wp_count    <= phws_pkg::WP_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        phws_pkg::REG_GAIN_P:     gain_p      <= cfg_wdata;
        phws_pkg::REG_GAIN_I:     gain_i      <= cfg_wdata;
        phws_pkg::REG_GAIN_D:     gain_d      <= cfg_wdata;
        phws_pkg::REG_DRIVE_LIM:  drive_limit <= phws_pkg::LIM_W'(cfg_wdata);
        phws_pkg::REG_ARRIVE_TOL: arrive_tol  <= phws_pkg::LIM_W'(cfg_wdata);
        phws_pkg::REG_WP_COUNT:   wp_count    <= phws_pkg::CNT_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign cnt_eff = (wp_count > MAX_CNT) ? MAX_CNT : wp_count;

  // Tracking state
  logic [phws_pkg::CNT_W-1:0]          cur_slot;
  logic signed [phws_pkg::SUM_W-1:0]   err_sum;
  logic signed [phws_pkg::ERR_W-1:0]   last_err;

  // Target table
  logic [phws_pkg::HEAD_W-1:0] target;
  logic                        slot_ok;

  assign slot_ok = (32'(in_slot) < MAX_WAYPOINTS);

  phws_ram #(
    .WIDTH (phws_pkg::HEAD_W),
    .DEPTH (MAX_WAYPOINTS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.table_write && slot_ok),
    .waddr (AW'(in_slot)),
    .wdata (in_heading),
    .raddr (AW'(cur_slot)),
    .rdata (target)
  );

  // Captured item
  logic signed [phws_pkg::HEAD_W-1:0] yaw;
  logic [phws_pkg::ELAP_W-1:0]        elapsed;
  logic                               fin_mode;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      yaw      <= in_heading;
      elapsed  <= in_elapsed;
      fin_mode <= (cur_slot >= cnt_eff);
    end
  end

  // Error and error difference, kept as sign and magnitude
  logic signed [phws_pkg::ERR_W-1:0]  err_c, err;
  logic signed [phws_pkg::DIFF_W-1:0] diff_c;
  logic [phws_pkg::ERR_W-1:0]         err_mag;
  logic [phws_pkg::DIFF_W-1:0]        diff_mag;
  logic                               err_neg, diff_neg;

  assign err_c  = phws_pkg::ERR_W'($signed(target)) - phws_pkg::ERR_W'(yaw);
  assign diff_c = phws_pkg::DIFF_W'(err_c) - phws_pkg::DIFF_W'(last_err);

  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      err      <= err_c;
      err_neg  <= err_c[phws_pkg::ERR_W-1];
      err_mag  <= err_c[phws_pkg::ERR_W-1] ? phws_pkg::ERR_W'(-err_c)
                                           : phws_pkg::ERR_W'(err_c);
      diff_neg <= diff_c[phws_pkg::DIFF_W-1];
      diff_mag <= diff_c[phws_pkg::DIFF_W-1] ? phws_pkg::DIFF_W'(-diff_c)
                                             : phws_pkg::DIFF_W'(diff_c);
    end
  end

  // Shared unsigned multiplier, product registered every cycle
  logic [phws_pkg::MUL_A_W-1:0] mul_a;
  logic [phws_pkg::MUL_B_W-1:0] mul_b;
  logic [phws_pkg::PROD_W-1:0]  prod;
  logic [phws_pkg::SUM_W-1:0]   sum_mag;

  always_comb begin
    case (cmd.mul_sel)
      phws_pkg::MUL_DIFF_GD: begin
        mul_a = phws_pkg::MUL_A_W'(diff_mag);
        mul_b = gain_d;
      end
      phws_pkg::MUL_ERR_EL: begin
        mul_a = phws_pkg::MUL_A_W'(err_mag);
        mul_b = elapsed;
      end
      phws_pkg::MUL_ERR_GP: begin
        mul_a = phws_pkg::MUL_A_W'(err_mag);
        mul_b = gain_p;
      end
      phws_pkg::MUL_SUM_LO: begin
        mul_a = sum_mag[phws_pkg::MUL_A_W-1:0];
        mul_b = gain_i;
      end
      phws_pkg::MUL_SUM_HI: begin
        mul_a = sum_mag[phws_pkg::SUM_W-1:phws_pkg::MUL_A_W];
        mul_b = gain_i;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= phws_pkg::PROD_W'(mul_a) * phws_pkg::PROD_W'(mul_b);
  end

  // Derivative divider: (|diff| * gain_d * 4) / elapsed
  logic                        div_busy;
  logic [phws_pkg::DNUM_W-1:0] quo;

  phws_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (phws_pkg::DNUM_W'({prod, 2'b00})),
    .den   (elapsed),
    .busy  (div_busy),
    .quo   (quo)
  );

  // Integral update with saturation
  logic signed [phws_pkg::TOT_W-1:0] prod_ext, sum_term, sum_wide;
  logic signed [phws_pkg::SUM_W-1:0] sum_sat, sum_new;

  always_comb begin
    prod_ext = $signed(phws_pkg::TOT_W'(prod));
    sum_term = err_neg ? -prod_ext : prod_ext;
    sum_wide = phws_pkg::TOT_W'(err_sum) + sum_term;
    if (sum_wide[phws_pkg::TOT_W-1] != sum_wide[phws_pkg::TOT_W-2]) begin
      sum_sat = sum_wide[phws_pkg::TOT_W-1] ? phws_pkg::SUM_MIN : phws_pkg::SUM_MAX;
    end else begin
      sum_sat = sum_wide[phws_pkg::SUM_W-1:0];
    end
  end

  // P, I and D terms
  logic signed [phws_pkg::P_W-1:0]   p_val;
  logic signed [phws_pkg::I_W-1:0]   i_val;
  logic signed [phws_pkg::D_W-1:0]   d_c;
  logic signed [phws_pkg::TOT_W-1:0] total;
  logic [phws_pkg::ACC_W-1:0]        acc;
  logic signed [phws_pkg::P_W-1:0]   p_mag;
  logic signed [phws_pkg::I_W-1:0]   i_mag;
  logic signed [phws_pkg::D_W-1:0]   d_mag;

  assign p_mag = $signed(phws_pkg::P_W'(prod >> phws_pkg::P_SHIFT));
  assign i_mag = $signed(phws_pkg::I_W'(acc >> phws_pkg::I_SHIFT));
  assign d_mag = $signed(phws_pkg::D_W'(quo));
  assign d_c   = (elapsed == '0) ? '0 : (diff_neg ? -d_mag : d_mag);

  always_ff @(posedge clk) begin
    if (cmd.load_sum) begin
      sum_new <= sum_sat;
    end
    if (cmd.load_p) begin
      p_val   <= err_neg ? -p_mag : p_mag;
      sum_mag <= sum_new[phws_pkg::SUM_W-1] ? phws_pkg::SUM_W'(-sum_new)
                                            : phws_pkg::SUM_W'(sum_new);
    end
    if (cmd.load_acc_lo) begin
      acc <= phws_pkg::ACC_W'(prod);
    end else if (cmd.load_acc_hi) begin
      acc <= acc + (phws_pkg::ACC_W'(prod) << phws_pkg::MUL_A_W);
    end
    if (cmd.load_i) begin
      i_val <= sum_new[phws_pkg::SUM_W-1] ? -i_mag : i_mag;
    end
    if (cmd.load_total) begin
      total <= phws_pkg::TOT_W'(p_val) + phws_pkg::TOT_W'(i_val) + phws_pkg::TOT_W'(d_c);
    end
  end

  // Clamp and arrival check
  logic signed [phws_pkg::TOT_W-1:0] lim_s, clamped;
  logic                              arrive;
  logic [phws_pkg::CNT_W-1:0]        slot_inc;

  assign lim_s    = $signed(phws_pkg::TOT_W'(drive_limit));
  assign clamped  = (total > lim_s) ? lim_s : ((total < -lim_s) ? -lim_s : total);
  assign arrive   = (err_mag < phws_pkg::ERR_W'(arrive_tol));
  assign slot_inc = cur_slot + 1'b1;

  // Commit: state update and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_slot <= '0;
      err_sum  <= '0;
      last_err <= '0;
    end else if (cmd.commit && !fin_mode) begin
      if (arrive) begin
        cur_slot <= slot_inc;
        err_sum  <= '0;
        last_err <= '0;
      end else begin
        err_sum  <= sum_new;
        last_err <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (fin_mode) begin
        out_drive   <= '0;
        out_reached <= 1'b0;
        out_wp      <= cur_slot;
        out_done    <= 1'b1;
      end else if (arrive) begin
        out_drive   <= '0;
        out_reached <= 1'b1;
        out_wp      <= slot_inc;
        out_done    <= (slot_inc >= cnt_eff);
      end else begin
        out_drive   <= phws_pkg::HEAD_W'(clamped);
        out_reached <= 1'b0;
        out_wp      <= cur_slot;
        out_done    <= (cur_slot >= cnt_eff);
      end
    end
  end

  // Status
  assign sts.finished = (cur_slot >= cnt_eff);
  assign sts.div_busy = div_busy;
  assign sts.out_busy = out_valid && !out_ready;

endmodule

### rtl/phws_ctrl.sv
// Controller state machine: sequences one control step through the datapath.
// Depends on phws_pkg command and status types.
module phws_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_action,
  output logic           in_ready,
  output phws_pkg::cmd_t cmd,
  input  phws_pkg::sts_t sts
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_ERR  = 13'b0000000000010,
    S_MD   = 13'b0000000000100,
    S_ME   = 13'b0000000001000,
    S_SUM  = 13'b0000000010000,
    S_MP   = 13'b0000000100000,
    S_ILO  = 13'b0000001000000,
    S_IHI  = 13'b0000010000000,
    S_IACC = 13'b0000100000000,
    S_IFIN = 13'b0001000000000,
    S_DIVW = 13'b0010000000000,
    S_ADD  = 13'b0100000000000,
    S_FIN  = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and command strobes
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = phws_pkg::MUL_DIFF_GD;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action) begin
            cmd.table_write = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_next  = sts.finished ? S_FIN : S_ERR;
          end
        end
      end
      S_ERR: begin
        cmd.load_err = 1'b1;
        state_next   = S_MD;
      end
      S_MD: begin
        cmd.mul_sel = phws_pkg::MUL_DIFF_GD;
        state_next  = S_ME;
      end
      S_ME: begin
        cmd.mul_sel   = phws_pkg::MUL_ERR_EL;
        cmd.div_start = 1'b1;
        state_next    = S_SUM;
      end
      S_SUM: begin
        cmd.load_sum = 1'b1;
        cmd.mul_sel  = phws_pkg::MUL_ERR_GP;
        state_next   = S_MP;
      end
      S_MP: begin
        cmd.load_p = 1'b1;
        state_next = S_ILO;
      end
      S_ILO: begin
        cmd.mul_sel = phws_pkg::MUL_SUM_LO;
        state_next  = S_IHI;
      end
      S_IHI: begin
        cmd.mul_sel     = phws_pkg::MUL_SUM_HI;
        cmd.load_acc_lo = 1'b1;
        state_next      = S_IACC;
      end
      S_IACC: begin
        cmd.load_acc_hi = 1'b1;
        state_next      = S_IFIN;
      end
      S_IFIN: begin
        cmd.load_i = 1'b1;
        state_next = S_DIVW;
      end
      S_DIVW: begin
        if (!sts.div_busy) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.load_total = 1'b1;
        state_next     = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/pid_heading_waypoint_stepper_top.sv
// Top level of the heading PID waypoint stepper: stream ports, config port.
// Instantiates phws_ctrl and phws_dp; uses phws_pkg.

// Load items (tuser = 1) write one target heading into the table and give no
// result. A control item (tuser = 0) gives one result. The derivative divider
// sets when it appears: it starts in S_ME, after S_ERR and S_MD, and retires
// two quotient bits a cycle over a 36-bit numerator, while the shared 24x16
// multiplier works out the P and I terms. The next item can be taken in the
// cycle the result appears. A control item that arrives after the last
// waypoint goes from acceptance straight to S_FIN and skips the arithmetic.
// One item is in work at a time. The result register lets the next item be
// taken while a result still waits on the output. A new result is held back
// while the previous one is still waiting. The target table comes out of
// reset unwritten: steer only toward slots already loaded. Config writes
// belong in idle periods only.
module pid_heading_waypoint_stepper_top #(
  parameter int MAX_WAYPOINTS = phws_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // config write port
  input  logic                                cfg_we,
  input  logic [phws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [phws_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [phws_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // slot[2:0], heading[18:3], elapsed[34:19]
  input  logic                                s_axis_tuser,  // action: 0 control step, 1 load
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [phws_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // drive[15:0], reached[16],
                                                             // waypoint_number[20:17], all_done[21]
);

  phws_pkg::cmd_t cmd;
  phws_pkg::sts_t sts;

  logic signed [phws_pkg::HEAD_W-1:0] out_drive;
  logic                               out_reached;
  logic [phws_pkg::CNT_W-1:0]         out_wp;
  logic                               out_done;

  phws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  phws_dp #(
    .MAX_WAYPOINTS (MAX_WAYPOINTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_slot     (s_axis_tdata[2:0]),
    .in_heading  ($signed(s_axis_tdata[18:3])),
    .in_elapsed  (s_axis_tdata[34:19]),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_drive   (out_drive),
    .out_reached (out_reached),
    .out_wp      (out_wp),
    .out_done    (out_done)
  );

  assign m_axis_tdata = {2'b00, out_done, out_wp, out_reached, out_drive};

  // One control step at a time: no new transaction right after one is taken
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
    else $error("input taken while a control step is in work");

  // Arrival or finish always reports zero drive
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[16] || m_axis_tdata[21]) |-> m_axis_tdata[15:0] == '0)
    else $error("nonzero drive on arrival or finish");

  // An arrival has advanced past at least one waypoint
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[20:17] != '0)
    else $error("arrival reported without advancing");

endmodule
